// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, the top level and the checker; depends on nothing else.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  typedef enum logic [1:0] {
    FUNC_PUT       = 2'd0,
    FUNC_BACKSPACE = 2'd1,
    FUNC_CLEAR     = 2'd2,
    FUNC_READ      = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
    logic        scrolled;
  } res_t;

endpackage

// ===== src/tcw_mem.sv =====
// Cell store: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tcw_ctrl.sv =====
// Sequencer of the text console writer: cursor, operation decode, scroll
// copy and fill sweeps over the cell store. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  req_t          req_i,
  output logic          done_o,
  output res_t          res_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [15:0]   mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [15:0]   mem_rdata_i
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int BOT    = (ROWS - 1) * COLUMNS;
  localparam int PW     = $clog2(CELLS + 1);
  localparam int CLW    = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;

  logic [2:0]     state_q, state_d;
  logic [PW-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]  wr_addr_q, wr_addr_d;
  logic           copy_wr_q, copy_wr_d;
  logic [15:0]    fill_word_q, fill_word_d;
  logic           report_q, report_d;
  logic           scrolled_q, scrolled_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [CLW-1:0] col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [7:0]     blank_attr_q;
  logic           done_q, done_d;
  res_t           res_q, res_d;
  logic           row_adv;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    wr_addr_d   = wr_addr_q;
    copy_wr_d   = copy_wr_q;
    fill_word_d = fill_word_q;
    report_d    = report_q;
    scrolled_d  = scrolled_q;
    pos_d       = pos_q;
    col_d       = col_q;
    row_d       = row_q;
    done_d      = 1'b0;
    res_d       = res_q;
    row_adv     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[AW-1:0];
    mem_wdata_o = {req_i.color, req_i.char_code};
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(req_i.cell_index);

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d.cell_data = 16'd0;
          res_d.scrolled  = 1'b0;
          case (req_i.func)
            FUNC_PUT: begin
              if (req_i.char_code == CH_NEWLINE) begin
                col_d   = '0;
                pos_d   = pos_q - PW'(col_q) + PW'(COLUMNS);
                row_adv = 1'b1;
              end else if (req_i.char_code == CH_RETURN) begin
                col_d = '0;
                pos_d = pos_q - PW'(col_q);
              end else begin
                mem_we_o = 1'b1;
                pos_d    = pos_q + PW'(1);
                if (col_q == CLW'(COLUMNS - 1)) begin
                  col_d   = '0;
                  row_adv = 1'b1;
                end else begin
                  col_d = col_q + CLW'(1);
                end
              end
              if (row_adv && row_q == RW'(ROWS - 1)) begin
                // The cursor stays on the last row while the rows move up.
                pos_d      = PW'(BOT);
                state_d    = ST_SCROLL;
                ptr_d      = PW'(COLUMNS);
                copy_wr_d  = 1'b0;
                scrolled_d = 1'b1;
              end else begin
                if (row_adv) begin
                  row_d = row_q + RW'(1);
                end
                done_d = 1'b1;
              end
            end
            FUNC_BACKSPACE: begin
              if (col_q != '0) begin
                col_d = col_q - CLW'(1);
                pos_d = pos_q - PW'(1);
              end else if (row_q != '0) begin
                row_d = row_q - RW'(1);
                col_d = CLW'(COLUMNS - 1);
                pos_d = pos_q - PW'(1);
              end
              mem_we_o    = 1'b1;
              mem_waddr_o = pos_d[AW-1:0];
              mem_wdata_o = {req_i.color, CH_SPACE};
              done_d      = 1'b1;
            end
            FUNC_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              pos_d       = '0;
              state_d     = ST_FILL;
              ptr_d       = '0;
              fill_word_d = {blank_attr_q, CH_SPACE};
              report_d    = 1'b1;
              scrolled_d  = 1'b0;
            end
            default: begin
              if (32'(req_i.cell_index) < CELLS) begin
                mem_re_o = 1'b1;
                state_d  = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
          endcase
          res_d.cursor_pos = 11'(pos_d);
        end
      end
      ST_READ: begin
        done_d          = 1'b1;
        res_d.cell_data = mem_rdata_i;
        state_d         = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one row ahead and write the word back one row higher in the following cycle.
        mem_we_o    = copy_wr_q;
        mem_waddr_o = wr_addr_q;
        mem_wdata_o = mem_rdata_i;
        mem_raddr_o = ptr_q[AW-1:0];
        if (ptr_q != PW'(CELLS)) begin
          mem_re_o  = 1'b1;
          ptr_d     = ptr_q + PW'(1);
          copy_wr_d = 1'b1;
          wr_addr_d = AW'(ptr_q - PW'(COLUMNS));
        end else begin
          copy_wr_d   = 1'b0;
          state_d     = ST_FILL;
          ptr_d       = PW'(BOT);
          fill_word_d = {blank_attr_q, CH_SPACE};
          report_d    = 1'b1;
        end
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AW-1:0];
        mem_wdata_o = fill_word_q;
        ptr_d       = ptr_q + PW'(1);
        if (ptr_q == PW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          if (report_q) begin
            done_d           = 1'b1;
            res_d.cursor_pos = 11'(pos_q);
            res_d.cell_data  = 16'd0;
            res_d.scrolled   = scrolled_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // After reset the store is swept once with plain spaces before any item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      ptr_q        <= '0;
      copy_wr_q    <= 1'b0;
      fill_word_q  <= {8'd0, CH_SPACE};
      report_q     <= 1'b0;
      scrolled_q   <= 1'b0;
      pos_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      blank_attr_q <= 8'd0;
      done_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      copy_wr_q   <= copy_wr_d;
      fill_word_q <= fill_word_d;
      report_q    <= report_d;
      scrolled_q  <= scrolled_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    res_q     <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/text_console_writer_top.sv =====
// Top level of the text console writer: sequencer and cell store.
// Depends on tcw_pkg, tcw_ctrl and tcw_mem.

// A put of a character, a newline, a carriage return, a backspace or a read
// of an address beyond the screen is taken while busy_o is low and its
// result is on res_o, marked by done_o, in the next cycle, so such items may
// follow each other in every cycle. A read of a cell passes through the
// ST_READ state, because the cell store registers its read data, and keeps
// busy_o high meanwhile. A put that runs past the last row scrolls the
// screen: the cell store has one write port, so the rows are moved up one
// word at a time and the bottom row is then blanked, with busy_o high until
// the result appears. A clear keeps busy_o high while every cell is written
// with the blank word. After reset the store is swept to blank spaces, which
// holds busy_o high while it runs; the blank attribute register may be
// written during that time. Results cannot be held off: each is valid for
// the single cycle in which done_o is high.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  req_t       req_i,
  output logic       done_o,
  output res_t       res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== src/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to its top level.
// Depends on tcw_pkg and text_console_writer_top.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input req_t req_i,
  input logic done_i,
  input res_t res_i
);

  logic take;
  assign take = start_i && !busy_i;

  // A result is only ever given as the block returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result shown while busy");

  // A backspace transfer completes in the next cycle without a scroll.
  a_bs_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.func == FUNC_BACKSPACE |=> done_i && !res_i.scrolled)
    else $error("backspace result missing");

  // A clear starts a sweep that keeps the block busy, with no result yet.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.func == FUNC_CLEAR |=> busy_i && !done_i)
    else $error("clear did not start a sweep");

  // After a scroll the cursor stands at the start of the last row.
  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && res_i.scrolled |->
      res_i.cursor_pos == 11'((ROWS - 1) * COLUMNS) && res_i.cell_data == 16'd0)
    else $error("scroll left cursor elsewhere");

  // An in-range read holds the block busy in ST_READ before done_i marks its cell.
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.func == FUNC_READ && 32'(req_i.cell_index) < COLUMNS * ROWS
      |=> busy_i ##1 done_i)
    else $error("read result late");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .req_i   (req_i),
  .done_i  (done_o),
  .res_i   (res_o)
);
